@@ hw/rtl/gbn_pkg.sv @@
// Shared types and constants for the greedy box suppression block.
// Holds the controller state type, the command and status structs and reset values.
// No dependencies.
package gbn_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic issue;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_more;
      logic pipe_busy;
   } dp_status_type;

   typedef enum logic [1:0] {
      CSR_OVERLAP_THRESHOLD = 2'd0,
      CSR_DECAY_FACTOR      = 2'd1,
      CSR_CANDIDATE_LIMIT   = 2'd2
   } csr_index_type;

   localparam int           COORD_W         = 16;
   localparam int           AREA_W          = 32;
   localparam int           ENTRY_W         = 4 * COORD_W + AREA_W;
   localparam int           THR_W           = 17;
   localparam logic [16:0]  THR_RESET       = 17'd19661;
   localparam logic [16:0]  DECAY_RESET     = 17'd65536;
   localparam logic [7:0]   LIMIT_RESET     = 8'd100;
   localparam logic [16:0]  THR_ONE         = 17'd65536;
   localparam logic [16:0]  THR_HALF        = 17'd32768;
   localparam logic [7:0]   SEEN_MAX        = 8'd255;

endpackage

@@ hw/rtl/gbn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stores the kept box list; no dependencies.
module gbn_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/gbn_ctrl.sv @@
// Controller state machine for the greedy box suppression block.
// Depends on gbn_pkg for the state, command and status types.
module gbn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gbn_pkg::dp_status_type status,
   output gbn_pkg::ctrl_cmd_type  cmd
);

   gbn_pkg::state_type state_ff;
   gbn_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbn_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbn_pkg::ST_IDLE: begin
            if (start) begin
               state_in = gbn_pkg::ST_PREP;
            end
         end
         gbn_pkg::ST_PREP: begin
            state_in = gbn_pkg::ST_SCAN;
         end
         gbn_pkg::ST_SCAN: begin
            if (!status.scan_more && !status.pipe_busy) begin
               state_in = gbn_pkg::ST_COMMIT;
            end
         end
         gbn_pkg::ST_COMMIT: begin
            state_in = gbn_pkg::ST_IDLE;
         end
         default: begin
            state_in = gbn_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         gbn_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         gbn_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
         end
         gbn_pkg::ST_SCAN: begin
            cmd.issue = status.scan_more;
         end
         gbn_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

@@ hw/rtl/gbn_dp.sv @@
// Datapath for the greedy box suppression block: settings, candidate registers,
// overlap compare pipeline and list update. Depends on gbn_pkg and gbn_ram.
module gbn_dp #(
   parameter int MAX_KEPT = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gbn_pkg::ctrl_cmd_type  cmd,
   output gbn_pkg::dp_status_type status,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_index,
   input  logic [16:0]            csr_wdata,
   input  logic                   req_first_of_set,
   input  logic signed [15:0]     req_left_edge,
   input  logic signed [15:0]     req_top_edge,
   input  logic signed [15:0]     req_right_edge,
   input  logic signed [15:0]     req_bottom_edge,
   input  logic [15:0]            req_score_in,
   input  logic [11:0]            req_candidate_id,
   output logic                   rsp_valid,
   output logic                   rsp_kept,
   output logic [15:0]            rsp_score_out,
   output logic [11:0]            rsp_id_out,
   output logic [7:0]             rsp_kept_total
);

   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int EW = gbn_pkg::ENTRY_W;

   // settings
   logic [16:0] thr_cfg_ff;
   logic [16:0] eta_ff;
   logic [7:0]  limit_ff;

   // candidate
   logic signed [15:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [15:0]        score_ff;
   logic [11:0]        id_ff;
   logic [31:0]        area_a_ff, area_a_in;

   // set state
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    seen_ff, seen_in;
   logic [16:0]   thr_ff, thr_in;
   logic          elig_ff, elig_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic          suppress_ff, suppress_in;

   // compare pipeline
   logic               rd_v_ff, b_v_ff, c_v_ff, d_v_ff;
   logic               b_gap_ff, b_gap_in;
   logic signed [16:0] b_iw_ff, b_iw_in, b_ih_ff, b_ih_in;
   logic [31:0]        b_area_ff;
   logic               c_gap_ff;
   logic signed [33:0] c_inter_ff, c_inter_in;
   logic [32:0]        c_total_ff;
   logic               d_gap_ff;
   logic signed [52:0] d_lhs_ff, d_lhs_in;
   logic [49:0]        d_rhs_ff, d_rhs_in;

   // response
   logic        rsp_valid_ff;
   logic        rsp_kept_ff, rsp_kept_in;
   logic [15:0] rsp_score_ff;
   logic [11:0] rsp_id_ff;
   logic [7:0]  rsp_total_ff, rsp_total_in;

   // memory
   logic          wr_en;
   logic [EW-1:0] wr_data;
   logic [EW-1:0] rd_data;

   logic               keep_now;
   logic [33:0]        decay_prod;
   logic [CW+7:0]      total_wide;
   logic signed [15:0] bx0, by0, bx1, by1;

   gbn_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_KEPT)
   ) u_list (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.issue),
      .rd_addr (addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign wr_data = {y1_ff, x1_ff, y0_ff, x0_ff, area_a_ff};
   assign bx0 = $signed(rd_data[47:32]);
   assign by0 = $signed(rd_data[63:48]);
   assign bx1 = $signed(rd_data[79:64]);
   assign by1 = $signed(rd_data[95:80]);

   assign status.scan_more = elig_ff && (addr_ff < count_ff);
   assign status.pipe_busy = rd_v_ff | b_v_ff | c_v_ff | d_v_ff;

   // settings write
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_cfg_ff <= gbn_pkg::THR_RESET;
         eta_ff     <= gbn_pkg::DECAY_RESET;
         limit_ff   <= gbn_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            gbn_pkg::CSR_OVERLAP_THRESHOLD: thr_cfg_ff <= csr_wdata;
            gbn_pkg::CSR_DECAY_FACTOR:      eta_ff     <= csr_wdata;
            gbn_pkg::CSR_CANDIDATE_LIMIT:   limit_ff   <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // candidate area, inverted box has none
   always_comb begin
      logic [16:0] dx;
      logic [16:0] dy;
      dx = 17'($signed(x1_ff) - $signed(x0_ff));
      dy = 17'($signed(y1_ff) - $signed(y0_ff));
      if (x1_ff < x0_ff || y1_ff < y0_ff) begin
         area_a_in = '0;
      end else begin
         area_a_in = dx[15:0] * dy[15:0];
      end
   end

   // overlap stages
   always_comb begin
      logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
      logic signed [18:0] thr_plus;
      lo_x     = (x0_ff > bx0) ? x0_ff : bx0;
      hi_x     = (x1_ff < bx1) ? x1_ff : bx1;
      lo_y     = (y0_ff > by0) ? y0_ff : by0;
      hi_y     = (y1_ff < by1) ? y1_ff : by1;
      b_gap_in = (bx0 > x1_ff) || (bx1 < x0_ff) || (by0 > y1_ff) || (by1 < y0_ff);
      b_iw_in  = 17'(hi_x) - 17'(lo_x);
      b_ih_in  = 17'(hi_y) - 17'(lo_y);
      c_inter_in = 34'(b_iw_ff) * 34'(b_ih_ff);
      thr_plus   = $signed({2'b00, thr_ff}) + $signed(19'd65536);
      d_lhs_in   = 53'(c_inter_ff) * 53'(thr_plus);
      d_rhs_in   = 50'(c_total_ff) * 50'(thr_ff);
   end

   always_ff @(posedge clock) begin
      b_gap_ff   <= b_gap_in;
      b_iw_ff    <= b_iw_in;
      b_ih_ff    <= b_ih_in;
      b_area_ff  <= rd_data[31:0];
      c_gap_ff   <= b_gap_ff;
      c_inter_ff <= c_inter_in;
      c_total_ff <= {1'b0, area_a_ff} + {1'b0, b_area_ff};
      d_gap_ff   <= c_gap_ff;
      d_lhs_ff   <= d_lhs_in;
      d_rhs_ff   <= d_rhs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         b_v_ff  <= 1'b0;
         c_v_ff  <= 1'b0;
         d_v_ff  <= 1'b0;
      end else begin
         rd_v_ff <= cmd.issue;
         b_v_ff  <= rd_v_ff;
         c_v_ff  <= b_v_ff;
         d_v_ff  <= c_v_ff;
      end
   end

   // set state and list update
   always_comb begin
      count_in    = count_ff;
      seen_in     = seen_ff;
      thr_in      = thr_ff;
      elig_in     = elig_ff;
      addr_in     = addr_ff;
      suppress_in = suppress_ff;
      wr_en       = 1'b0;
      keep_now    = elig_ff && !suppress_ff && (count_ff < CW'(MAX_KEPT));
      decay_prod  = thr_ff * eta_ff;
      if (cmd.capture) begin
         addr_in     = '0;
         suppress_in = 1'b0;
         if (req_first_of_set) begin
            count_in = '0;
            seen_in  = '0;
            thr_in   = thr_cfg_ff;
         end
      end
      if (cmd.prep) begin
         elig_in = seen_ff < limit_ff;
      end
      if (cmd.issue) begin
         addr_in = addr_ff + CW'(1);
      end
      if (d_v_ff && !d_gap_ff && (d_lhs_ff > $signed({3'b000, d_rhs_ff}))) begin
         suppress_in = 1'b1;
      end
      if (cmd.commit) begin
         if (keep_now) begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
            if (eta_ff < gbn_pkg::THR_ONE && thr_ff > gbn_pkg::THR_HALF) begin
               thr_in = decay_prod[32:16];
            end
         end
         if (seen_ff < gbn_pkg::SEEN_MAX) begin
            seen_in = seen_ff + 8'd1;
         end
      end
      total_wide   = {8'b0, count_in};
      rsp_total_in = total_wide[7:0];
      rsp_kept_in  = keep_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         seen_ff      <= '0;
         thr_ff       <= gbn_pkg::THR_RESET;
         elig_ff      <= 1'b0;
         addr_ff      <= '0;
         suppress_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         thr_ff       <= thr_in;
         elig_ff      <= elig_in;
         addr_ff      <= addr_in;
         suppress_ff  <= suppress_in;
         rsp_valid_ff <= cmd.commit;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x0_ff    <= req_left_edge;
         y0_ff    <= req_top_edge;
         x1_ff    <= req_right_edge;
         y1_ff    <= req_bottom_edge;
         score_ff <= req_score_in;
         id_ff    <= req_candidate_id;
      end
      if (cmd.prep) begin
         area_a_ff <= area_a_in;
      end
      if (cmd.commit) begin
         rsp_kept_ff  <= rsp_kept_in;
         rsp_score_ff <= score_ff;
         rsp_id_ff    <= id_ff;
         rsp_total_ff <= rsp_total_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept       = rsp_kept_ff;
   assign rsp_score_out  = rsp_score_ff;
   assign rsp_id_out     = rsp_id_ff;
   assign rsp_kept_total = rsp_total_ff;

endmodule

@@ hw/rtl/greedy_box_nms.sv @@
// Top level of the greedy box suppression block: controller plus datapath.
// Depends on gbn_pkg, gbn_ctrl, gbn_dp and gbn_ram.
//
// Candidates arrive sorted by falling score; pulse start while busy is low to
// transfer one. Its result follows a scan of the N boxes already kept in the
// current set (at most MAX_KEPT); nothing is scanned for an empty list or a
// candidate past top k. The kept list sits in one RAM read one entry per cycle
// into a four-stage overlap compare pipeline. A result shows for one cycle with
// rsp_valid high and cannot be stalled; the next candidate may start during that
// cycle. Settings are written through csr_valid/csr_ready (always ready); the
// user must do so only while the block is idle; the block does not enforce it.
module greedy_box_nms #(
   parameter int MAX_KEPT = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_first_of_set,
   input  logic signed [15:0] req_left_edge,
   input  logic signed [15:0] req_top_edge,
   input  logic signed [15:0] req_right_edge,
   input  logic signed [15:0] req_bottom_edge,
   input  logic [15:0]        req_score_in,
   input  logic [11:0]        req_candidate_id,
   output logic               rsp_valid,
   output logic               rsp_kept,
   output logic [15:0]        rsp_score_out,
   output logic [11:0]        rsp_id_out,
   output logic [7:0]         rsp_kept_total,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_wdata
);

   gbn_pkg::ctrl_cmd_type  cmd;
   gbn_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   gbn_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   gbn_dp #(
      .MAX_KEPT (MAX_KEPT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_first_of_set (req_first_of_set),
      .req_left_edge    (req_left_edge),
      .req_top_edge     (req_top_edge),
      .req_right_edge   (req_right_edge),
      .req_bottom_edge  (req_bottom_edge),
      .req_score_in     (req_score_in),
      .req_candidate_id (req_candidate_id),
      .rsp_valid        (rsp_valid),
      .rsp_kept         (rsp_kept),
      .rsp_score_out    (rsp_score_out),
      .rsp_id_out       (rsp_id_out),
      .rsp_kept_total   (rsp_kept_total)
   );

endmodule
